FILE: rtl/core/skeleton_pose_hierarchy_core_macros.svh
// Assertion macros shared by the pose hierarchy RTL.
// No dependencies; included by files that assert.
`ifndef SKELETON_POSE_HIERARCHY_CORE_MACROS_SVH
`define SKELETON_POSE_HIERARCHY_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SPH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SPH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/core/sph_pkg.sv
// Package for the pose hierarchy core: widths, joint type and fixed-point helpers.
// No dependencies.
package sph_pkg;
    localparam int MaxBones = 256;
    localparam int IdxW = $clog2(MaxBones);
    localparam int CntW = $clog2(MaxBones + 1);
    localparam logic [8:0] RootCode = 9'd256;
    localparam int JointW = 3 * 32 + 4 * 16 + 3 * 24;

    typedef struct packed {
        logic [23:0] sz;
        logic [23:0] sy;
        logic [23:0] sx;
        logic [15:0] qz;
        logic [15:0] qy;
        logic [15:0] qx;
        logic [15:0] qw;
        logic [31:0] tz;
        logic [31:0] ty;
        logic [31:0] tx;
    } joint_t;

    // Clamp a quaternion component to [-1, 1] in Q1.14.
    function automatic logic signed [15:0] qsat16(input logic signed [15:0] v);
        if (v > 16'sd16384) begin
            return 16'sd16384;
        end else if (v < -16'sd16384) begin
            return -16'sd16384;
        end
        return v;
    endfunction

    // Clamp a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sh80000000) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction
endpackage

FILE: rtl/core/sph_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module sph_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: rtl/core/skeleton_pose_hierarchy_core.sv
// Top level of the pose hierarchy core: sequencer, arithmetic and joint memory.
// Depends on sph_pkg, sph_ram and the assertion macro header.
// One bone is processed at a time. A root bone goes from its accepted beat straight
// to the output load. A child bone passes in order through one memory read of the
// parent joint, a quaternion/scale stage, a rotation-matrix stage, three rotate-and-add
// steps (one per output axis, on a shared set of three multipliers) and the output
// load. The core returns to idle after each output load before it accepts the next
// beat. A result that waits for m_tready holds the core in its output state, and
// s_tready stays low meanwhile.
`include "skeleton_pose_hierarchy_core_macros.svh"
module skeleton_pose_hierarchy_core
    import sph_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: local_tx, local_ty, local_tz, local_qw, local_qx, local_qy, local_qz,
    // local_sx, local_sy, local_sz, parent_index (from bit 0 up), padded to 248 bits
    input  logic [247:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: world_tx, world_ty, world_tz, world_qw, world_qx, world_qy, world_qz,
    // world_sx, world_sy, world_sz, bone_number (from bit 0 up)
    output logic [239:0] m_tdata,
    // tuser: parent_fault
    output logic         m_tuser
);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StRead = 3'd1;
    localparam logic [2:0] StQuat = 3'd2;
    localparam logic [2:0] StMat  = 3'd3;
    localparam logic [2:0] StRot  = 3'd4;
    localparam logic [2:0] StOut  = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [CntW-1:0] bone_reg;
    joint_t          loc_reg, res_reg, par;
    logic [8:0]      pidx;
    logic            child, fault, fault_reg;
    logic [1:0]      axis_reg;
    logic            ovalid_reg;
    logic [IdxW-1:0] bnum_reg;
    logic [IdxW-1:0] paddr_reg;
    logic [IdxW-1:0] rd_addr;
    logic            accept, wr_en, out_load;
    logic [JointW-1:0] rd_data;

    // Matrix, scaled translation and quaternion operands.
    logic signed [31:0] mat_reg [9];
    logic signed [31:0] v_reg [3];
    logic signed [15:0] p [4];
    logic signed [15:0] c [4];

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == StIdle);
    assign out_load = (state_reg == StOut) && (!ovalid_reg || m_tready);
    assign pidx = s_tdata[232 +: 9];
    assign child = (pidx != RootCode) && ({1'b0, pidx} < {1'b0, bone_reg})
                   && (pidx < 9'(MaxBones));
    assign fault = (pidx != RootCode) && !child;
    assign par = joint_t'(rd_data);

    // The parent address is held after the beat so the read data stays valid.
    assign rd_addr = (state_reg == StIdle) ? pidx[IdxW-1:0] : paddr_reg;

    // Joint memory holding every model-space joint of the pose.
    sph_ram #(.Width(JointW), .Depth(MaxBones)) u_mem (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(bnum_reg),
        .wr_data(JointW'(res_reg)),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );
    assign wr_en = out_load;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            p[k] = qsat16(par[96 + 16*k +: 16]);
            c[k] = qsat16(loc_reg[96 + 16*k +: 16]);
        end
    end

    // Quaternion, scale and scaled translation in one stage.
    logic signed [33:0] qs [4];
    logic signed [15:0] wq [4];
    logic [23:0]        ws [3];
    logic signed [56:0] tp [3];
    always_comb begin
        qs[0] = 34'(p[0]*c[0]) - 34'(p[1]*c[1]) - 34'(p[2]*c[2]) - 34'(p[3]*c[3]);
        qs[1] = 34'(p[0]*c[1]) + 34'(p[1]*c[0]) + 34'(p[2]*c[3]) - 34'(p[3]*c[2]);
        qs[2] = 34'(p[0]*c[2]) - 34'(p[1]*c[3]) + 34'(p[2]*c[0]) + 34'(p[3]*c[1]);
        qs[3] = 34'(p[0]*c[3]) + 34'(p[1]*c[2]) - 34'(p[2]*c[1]) + 34'(p[3]*c[0]);
        for (int k = 0; k < 4; k++) begin
            logic signed [33:0] r;
            r = (qs[k] + 34'sd8192) >>> 14;
            wq[k] = (r > 34'sd16384) ? 16'sd16384 :
                    (r < -34'sd16384) ? -16'sd16384 : r[15:0];
        end
        for (int k = 0; k < 3; k++) begin
            logic [48:0] s;
            logic signed [56:0] t;
            s = 49'(loc_reg[160 + 24*k +: 24] * par[160 + 24*k +: 24]) + 49'd32768;
            ws[k] = (s[48:40] != 9'd0) ? 24'hFFFFFF : s[39:16];
            t = 57'($signed(loc_reg[32*k +: 32]) * $signed({1'b0, par[160 + 24*k +: 24]}));
            tp[k] = (t + 57'sd32768) >>> 16;
        end
    end

    // Rotation matrix from the parent quaternion, Q.28.
    logic signed [31:0] mat [9];
    always_comb begin
        logic signed [31:0] w, x, y, z;
        w = p[0]; x = p[1]; y = p[2]; z = p[3];
        mat[0] = 32'sd268435456 - 2 * (y*y + z*z);
        mat[1] = 2 * (x*y - w*z);
        mat[2] = 2 * (x*z + w*y);
        mat[3] = 2 * (x*y + w*z);
        mat[4] = 32'sd268435456 - 2 * (x*x + z*z);
        mat[5] = 2 * (y*z - w*x);
        mat[6] = 2 * (x*z - w*y);
        mat[7] = 2 * (y*z + w*x);
        mat[8] = 32'sd268435456 - 2 * (x*x + y*y);
    end

    // One output axis per cycle through three shared multipliers.
    logic signed [65:0] acc;
    logic signed [63:0] rt;
    always_comb begin
        acc = 66'(mat_reg[3*axis_reg] * v_reg[0]) + 66'(mat_reg[3*axis_reg+1] * v_reg[1])
            + 66'(mat_reg[3*axis_reg+2] * v_reg[2]) + 66'sd134217728;
        rt = 64'(acc >>> 28) + 64'($signed(par[32*axis_reg +: 32]));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            StIdle: if (accept) state_next = child ? StRead : StOut;
            StRead: state_next = StQuat;
            StQuat: state_next = StMat;
            StMat:  state_next = StRot;
            StRot:  if (axis_reg == 2'd2) state_next = StOut;
            StOut:  if (out_load) state_next = StIdle;
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= StIdle;
            bone_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
            if (accept) begin
                bone_reg <= (s_tlast || bone_reg >= CntW'(MaxBones - 1)) ? '0 : bone_reg + 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            loc_reg   <= joint_t'(s_tdata[JointW-1:0]);
            res_reg   <= joint_t'(s_tdata[JointW-1:0]);
            fault_reg <= fault;
            bnum_reg  <= bone_reg[IdxW-1:0];
            paddr_reg <= pidx[IdxW-1:0];
            axis_reg  <= 2'd0;
        end
        if (state_reg == StQuat) begin
            for (int k = 0; k < 4; k++) res_reg[96 + 16*k +: 16] <= wq[k];
            for (int k = 0; k < 3; k++) begin
                res_reg[160 + 24*k +: 24] <= ws[k];
                v_reg[k] <= sat32(64'(tp[k]));
            end
        end
        if (state_reg == StMat) begin
            for (int k = 0; k < 9; k++) mat_reg[k] <= mat[k];
        end
        if (state_reg == StRot) begin
            res_reg[32*axis_reg +: 32] <= sat32(rt);
            axis_reg <= axis_reg + 2'd1;
        end
        if (out_load) begin
            m_tdata <= {bnum_reg, JointW'(res_reg)};
            m_tuser <= fault_reg;
        end
    end
    assign m_tvalid = ovalid_reg;

    `SPH_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != StIdle, !s_tready)
    `SPH_ASSERT_NEXT(a_out_after_done, aclk, aresetn, state_reg == StOut, m_tvalid)
    `SPH_ASSERT_NEXT(a_child_reads, aclk, aresetn, accept && child, state_reg == StRead)
    `SPH_ASSERT_IMPL(a_axis_range, aclk, aresetn, state_reg == StRot, axis_reg != 2'd3)
endmodule
